// ===== rtl/sorted_unique_byte_set_core_assert.svh =====
// Assertion macros used by the checker file of the sorted byte set.
`ifndef SORTED_UNIQUE_BYTE_SET_CORE_ASSERT_SVH
`define SORTED_UNIQUE_BYTE_SET_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SUBS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("subs assertion failed");

// Next-cycle implication, disabled during reset.
`define SUBS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("subs assertion failed");

`endif

// ===== rtl/subs_pkg.sv =====
// ----------------------------------------------------------------------------
// subs_pkg
// Types and codes shared by the sorted byte set core, its cells and checker.
// ----------------------------------------------------------------------------
package subs_pkg;

  typedef logic signed [7:0] key_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LIST   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DUMP = 2'd2
  } fsm_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t op;
    key_t     key;
  } cell_ctl_t;

endpackage

// ===== rtl/subs_cell.sv =====
// ----------------------------------------------------------------------------
// subs_cell
// One slot of the sorted chain: holds a key, compares it against the command
// key and shifts or rotates with its neighbors.
// ----------------------------------------------------------------------------
module subs_cell (
  input  logic               clk,
  input  subs_pkg::cell_ctl_t ctl,
  input  logic               valid,
  input  logic               left_lt,
  input  subs_pkg::key_t     left_key,
  input  subs_pkg::key_t     right_key,
  input  subs_pkg::key_t     head_key,
  input  logic               is_tail,
  output subs_pkg::key_t     key_q,
  output logic               lt,
  output logic               eq
);
  import subs_pkg::*;

  key_t key_r;
  key_t key_nxt;

  // Compare held key against the command key
  assign lt    = valid && (key_r < ctl.key);
  assign eq    = valid && (key_r == ctl.key);
  assign key_q = key_r;

  // Pick next key: keep below the insert/remove point, shift above it
  always_comb begin
    key_nxt = key_r;
    unique case (ctl.op)
      CELL_HOLD: key_nxt = key_r;
      CELL_INSERT: begin
        if (!lt) begin
          key_nxt = left_lt ? ctl.key : left_key;
        end
      end
      CELL_REMOVE: begin
        if (!lt) begin
          key_nxt = right_key;
        end
      end
      CELL_ROTATE: key_nxt = is_tail ? head_key : right_key;
      default: key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ===== rtl/subs_chain.sv =====
// ----------------------------------------------------------------------------
// subs_chain
// Row of CAPACITY cells kept in ascending order; reports a key match and
// presents the head key for list and clear walks.
// ----------------------------------------------------------------------------
module subs_chain #(
  parameter int CAPACITY = 32,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  subs_pkg::cell_ctl_t ctl,
  input  logic [CNT_W-1:0]    count,
  output logic                found,
  output subs_pkg::key_t      head_key
);
  import subs_pkg::*;

  key_t                keys  [CAPACITY];
  logic [CAPACITY-1:0] lt_v;
  logic [CAPACITY-1:0] eq_v;
  logic [CNT_W-1:0]    tail_idx;

  assign tail_idx = count - CNT_W'(1);
  assign head_key = keys[0];
  assign found    = |eq_v;

  // Build the row, each cell wired to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic left_lt;
    key_t left_key;
    key_t right_key;

    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_key = ctl.key;
    end else begin : g_mid
      assign left_lt  = lt_v[i-1];
      assign left_key = keys[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = keys[i];
    end else begin : g_inner
      assign right_key = keys[i+1];
    end

    subs_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .valid     (CNT_W'(i) < count),
      .left_lt   (left_lt),
      .left_key  (left_key),
      .right_key (right_key),
      .head_key  (keys[0]),
      .is_tail   (CNT_W'(i) == tail_idx),
      .key_q     (keys[i]),
      .lt        (lt_v[i]),
      .eq        (eq_v[i])
    );
  end

endmodule

// ===== rtl/sorted_unique_byte_set_core.sv =====
// ----------------------------------------------------------------------------
// sorted_unique_byte_set_core
// Sorted set of distinct signed byte keys held in a chain of compare cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries a command in_cmd and key in_key:
//   insert, remove, list all, clear all. Results leave on out_valid/out_ready
//   with out_status, out_value and out_last (set on the final result).
//   A command is captured in S_IDLE and executed in S_EXEC, where every
//   cell compares its key in parallel and the row shifts in place; the
//   insert or remove result is then registered in the output register.
//   List and clear walk the row by rotating it one slot a cycle while the
//   output register is free, emitting the head key at each step.
//   in_ready is high only between commands; one command is in work at a time.
//   A result waits in the output register while out_ready is low, and the
//   walk or command holds until it is taken.
//   Reset empties the set; the key slots themselves are not cleared.
// ----------------------------------------------------------------------------
module sorted_unique_byte_set_core #(
  parameter int CAPACITY = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_cmd,
  input  subs_pkg::key_t       in_key,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output subs_pkg::key_t       out_value,
  output logic                 out_last
);
  import subs_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  fsm_t             state_r,   state_nxt;
  cmd_t             cmd_r;
  key_t             key_r;
  logic [CNT_W-1:0] count_r,   count_nxt;
  logic [CNT_W-1:0] idx_r,     idx_nxt;
  logic             out_valid_r;
  status_t          out_status_r, out_status_nxt;
  key_t             out_value_r,  out_value_nxt;
  logic             out_last_r,   out_last_nxt;
  logic             out_load;
  logic             out_free;
  cell_ctl_t        ctl;
  logic             found;
  key_t             head_key;

  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

  subs_chain #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .count    (count_r),
    .found    (found),
    .head_key (head_key)
  );

  // Sequence commands and drive the cell row
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    ctl.op         = CELL_HOLD;
    ctl.key        = key_r;
    out_load       = 1'b0;
    out_status_nxt = ST_OK;
    out_value_nxt  = '0;
    out_last_nxt   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          unique case (cmd_r)
            CMD_INSERT: begin
              out_load = 1'b1;
              if (found) begin
                out_status_nxt = ST_DUP;
              end else if (count_r == CNT_W'(CAPACITY)) begin
                out_status_nxt = ST_FULL;
              end else begin
                ctl.op        = CELL_INSERT;
                count_nxt     = count_r + CNT_W'(1);
                out_value_nxt = key_r;
              end
            end
            CMD_REMOVE: begin
              out_load = 1'b1;
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else if (!found) begin
                out_status_nxt = ST_NOTFOUND;
              end else begin
                ctl.op        = CELL_REMOVE;
                count_nxt     = count_r - CNT_W'(1);
                out_value_nxt = key_r;
              end
            end
            CMD_LIST, CMD_CLEAR: begin
              if (count_r == '0) begin
                out_load       = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_DUMP;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DUMP: begin
        // Emit the head and rotate the row by one slot
        if (out_free) begin
          out_load      = 1'b1;
          out_value_nxt = head_key;
          out_last_nxt  = (idx_r == count_r - CNT_W'(1));
          ctl.op        = CELL_ROTATE;
          idx_nxt       = idx_r + CNT_W'(1);
          if (out_last_nxt) begin
            state_nxt = S_IDLE;
            if (cmd_r == CMD_CLEAR) begin
              count_nxt = '0;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Command capture, walk index and result payload
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (in_valid && in_ready) begin
      cmd_r <= cmd_t'(in_cmd);
      key_r <= in_key;
    end
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_value_r  <= out_value_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

endmodule

// ===== rtl/subs_checker.sv =====
// ----------------------------------------------------------------------------
// subs_checker
// Port-level checks on the sorted byte set core, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_unique_byte_set_core_assert.svh"

module subs_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [2:0]       out_status,
  input subs_pkg::key_t   out_value,
  input logic             out_last
);
  import subs_pkg::*;

  // Hold a stalled result
  `SUBS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_last))

  // Error results carry zero and close the command
  `SUBS_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && out_status != ST_OK, out_value == '0 && out_last)

  // One command in work at a time
  `SUBS_ASSERT_NXT(a_one_cmd, clk, rst_n, in_valid && in_ready, !in_ready)

  // Status codes stay in range
  `SUBS_ASSERT_IMP(a_status_rng, clk, rst_n, out_valid, out_status <= ST_FULL)

endmodule

bind sorted_unique_byte_set_core subs_checker u_subs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_status (out_status),
  .out_value  (out_value),
  .out_last   (out_last)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted byte set: table-driven directed commands
// followed by phased random traffic, scored against an in-bench model of the
// sorted store with random idle gaps on both handshakes.
// ----------------------------------------------------------------------------
module tb_top;
  import subs_pkg::*;

  localparam int CAPACITY     = 32;
  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;
  localparam int CYCLE_LIMIT  = 1_200_000;
  localparam int REPORT_MAX   = 10;
  localparam int KEY_STEP     = 7;

  typedef struct {
    status_t status;
    key_t    value;
    logic    last;
  } result_t;

  typedef struct {
    cmd_t    cmd;
    key_t    key;
    int      reps;
    bit      typed;
    status_t status;
    key_t    value;
  } dir_row_t;

  localparam int NUM_DIR = 22;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  logic [1:0]     in_cmd;
  key_t           in_key;
  logic           out_valid;
  logic           out_ready;
  logic [2:0]     out_status;
  key_t           out_value;
  logic           out_last;

  // Model of the store and the results still owed by the block
  key_t           set_keys [CAPACITY];
  int             set_count;
  result_t        fresh_results [$];
  result_t        pending_results [$];

  int             mismatch_count;
  int             result_index;
  int             cycle_count;
  int             stall_left;
  bit             calm;
  dir_row_t       dir_tab [NUM_DIR];

  sorted_unique_byte_set_core #(
    .CAPACITY (CAPACITY)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_key     (in_key),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_value  (out_value),
    .out_last   (out_last)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("MISMATCH: %s", msg);
  endtask

  // Apply one command to the model store; results land in fresh_results
  task automatic set_apply_cmd(input cmd_t c, input key_t k);
    int pos;
    fresh_results.delete();
    pos = 0;
    while (pos < set_count && set_keys[pos] < k) pos++;
    case (c)
      CMD_INSERT: begin
        if (pos < set_count && set_keys[pos] == k) begin
          fresh_results.push_back('{ST_DUP, key_t'(0), 1'b1});
        end else if (set_count >= CAPACITY) begin
          fresh_results.push_back('{ST_FULL, key_t'(0), 1'b1});
        end else begin
          for (int j = set_count; j > pos; j--) set_keys[j] = set_keys[j - 1];
          set_keys[pos] = k;
          set_count++;
          fresh_results.push_back('{ST_OK, k, 1'b1});
        end
      end
      CMD_REMOVE: begin
        if (set_count == 0) begin
          fresh_results.push_back('{ST_EMPTY, key_t'(0), 1'b1});
        end else if (pos >= set_count || set_keys[pos] != k) begin
          fresh_results.push_back('{ST_NOTFOUND, key_t'(0), 1'b1});
        end else begin
          for (int j = pos; j + 1 < set_count; j++) set_keys[j] = set_keys[j + 1];
          set_count--;
          fresh_results.push_back('{ST_OK, k, 1'b1});
        end
      end
      default: begin
        if (set_count == 0) begin
          fresh_results.push_back('{ST_EMPTY, key_t'(0), 1'b1});
        end else begin
          for (int j = 0; j < set_count; j++)
            fresh_results.push_back('{ST_OK, set_keys[j], logic'(j + 1 == set_count)});
          if (c == CMD_CLEAR) set_count = 0;
        end
      end
    endcase
  endtask

  // Idle length between transfers: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 16);
  endfunction

  // Present one command, hold it until the transfer, then book its results
  task automatic send_cmd(input cmd_t c, input key_t k, input bit typed,
                          input status_t st, input key_t val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= c;
    in_key   <= k;
    do @(posedge clk); while (in_ready !== 1'b1);
    set_apply_cmd(c, k);
    if (typed) begin
      pending_results.push_back('{st, val, 1'b1});
    end else begin
      foreach (fresh_results[i]) pending_results.push_back(fresh_results[i]);
    end
    @(negedge clk);
  endtask

  // Key for random traffic: present keys, edge keys, or anything
  function automatic key_t pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40 && set_count > 0) return set_keys[$urandom_range(0, set_count - 1)];
    if (r < 60) begin
      case ($urandom_range(0, 5))
        0: return key_t'(8'h80);
        1: return key_t'(8'h81);
        2: return key_t'(8'h7F);
        3: return key_t'(8'h7E);
        4: return key_t'(8'h00);
        default: return key_t'(8'hFF);
      endcase
    end
    return key_t'($urandom_range(0, 255));
  endfunction

  // Command mix per phase: fill, drain, or mixed
  function automatic cmd_t pick_cmd(input int phase);
    int r;
    r = $urandom_range(0, 99);
    case (phase)
      0: begin
        if (r < 82) return CMD_INSERT;
        if (r < 90) return CMD_REMOVE;
        if (r < 98) return CMD_LIST;
        return CMD_CLEAR;
      end
      1: begin
        if (r < 15) return CMD_INSERT;
        if (r < 88) return CMD_REMOVE;
        if (r < 96) return CMD_LIST;
        return CMD_CLEAR;
      end
      default: begin
        if (r < 35) return CMD_INSERT;
        if (r < 70) return CMD_REMOVE;
        if (r < 90) return CMD_LIST;
        return CMD_CLEAR;
      end
    endcase
  endfunction

  // Receiver: random back-pressure, none during calm stretches
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0 && !calm) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready  <= 1'b1;
        stall_left = 0;
        if (!calm && $urandom_range(0, 7) == 0) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 16)
                                                   : $urandom_range(1, 3);
        end
      end
    end
  end

  // Score each result transfer against the oldest expectation
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result %0d with none expected: status %0d value %0d last %0d",
                                result_index, out_status, out_value, out_last));
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status || out_value !== exp_r.value ||
            out_last !== exp_r.last) begin
          note_mismatch($sformatf(
            "result %0d: expected status %0d value %0d last %0d, got status %0d value %0d last %0d",
            result_index, exp_r.status, exp_r.value, exp_r.last,
            out_status, out_value, out_last));
        end
      end
      result_index++;
    end
  end

  // Stimulus and end of run
  initial begin
    int phase;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = CMD_INSERT;
    in_key         = '0;
    calm           = 1'b0;
    mismatch_count = 0;
    result_index   = 0;
    cycle_count    = 0;
    set_count      = 0;

    dir_tab = '{
      '{CMD_REMOVE, key_t'(0),    1, 1'b1, ST_EMPTY,    key_t'(0)},
      '{CMD_LIST,   key_t'(0),    1, 1'b1, ST_EMPTY,    key_t'(0)},
      '{CMD_CLEAR,  key_t'(-1),   1, 1'b1, ST_EMPTY,    key_t'(0)},
      '{CMD_INSERT, key_t'(127),  1, 1'b1, ST_OK,       key_t'(127)},
      '{CMD_INSERT, key_t'(-128), 1, 1'b1, ST_OK,       key_t'(-128)},
      '{CMD_INSERT, key_t'(127),  1, 1'b1, ST_DUP,      key_t'(0)},
      '{CMD_INSERT, key_t'(0),    1, 1'b1, ST_OK,       key_t'(0)},
      '{CMD_INSERT, key_t'(-1),   1, 1'b0, ST_OK,       key_t'(0)},
      '{CMD_LIST,   key_t'(-1),   1, 1'b0, ST_OK,       key_t'(0)},
      '{CMD_REMOVE, key_t'(5),    1, 1'b1, ST_NOTFOUND, key_t'(0)},
      '{CMD_REMOVE, key_t'(-128), 1, 1'b1, ST_OK,       key_t'(-128)},
      '{CMD_REMOVE, key_t'(-128), 1, 1'b1, ST_NOTFOUND, key_t'(0)},
      '{CMD_CLEAR,  key_t'(85),   1, 1'b0, ST_OK,       key_t'(0)},
      '{CMD_LIST,   key_t'(-86),  1, 1'b1, ST_EMPTY,    key_t'(0)},
      // fill to capacity with spread keys, then probe the full store
      '{CMD_INSERT, key_t'(-100), CAPACITY, 1'b0, ST_OK, key_t'(0)},
      '{CMD_INSERT, key_t'(120),  1, 1'b1, ST_FULL,     key_t'(0)},
      '{CMD_INSERT, key_t'(-100), 1, 1'b1, ST_DUP,      key_t'(0)},
      '{CMD_LIST,   key_t'(0),    1, 1'b0, ST_OK,       key_t'(0)},
      '{CMD_REMOVE, key_t'(117),  1, 1'b1, ST_OK,       key_t'(117)},
      '{CMD_INSERT, key_t'(120),  1, 1'b1, ST_OK,       key_t'(120)},
      '{CMD_CLEAR,  key_t'(0),    1, 1'b0, ST_OK,       key_t'(0)},
      '{CMD_REMOVE, key_t'(120),  1, 1'b1, ST_EMPTY,    key_t'(0)}
    };

    // Reset once
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    for (int r = 0; r < NUM_DIR; r++) begin
      for (int n = 0; n < dir_tab[r].reps; n++) begin
        send_cmd(dir_tab[r].cmd, dir_tab[r].key + key_t'(n * KEY_STEP),
                 dir_tab[r].typed, dir_tab[r].status, dir_tab[r].value);
      end
    end

    // Random traffic in phases, with calm stretches of back-to-back transfers
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      phase = (i / 60) % 3;
      calm  = ((i % 100) >= 80);
      send_cmd(pick_cmd(phase), pick_key(), 1'b0, ST_OK, key_t'(0));
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain and let the block settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_results.size() != 0) begin
      note_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
